/* rtl/mf3_pkg.sv */
package mf3_pkg;

  localparam int CHAN_BITS     = 8;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 4;
  localparam int WIN_SIZE      = 9;
  localparam int ROW_BITS      = 12;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic                 pixel_valid;
    logic [CHAN_BITS-1:0] red_in;
    logic [CHAN_BITS-1:0] green_in;
    logic [CHAN_BITS-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red_out;
    logic [CHAN_BITS-1:0] green_out;
    logic [CHAN_BITS-1:0] blue_out;
    logic                 frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
  } pixel_t;

  // one neighbourhood ready for the median: column-major window, clip mask
  typedef struct packed {
    pixel_t [WIN_SIZE-1:0] win;
    logic   [WIN_SIZE-1:0] mask;
    logic                  last;
  } entry_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [11:0] data;
  } cfg_wr_t;

endpackage

/* rtl/mf3_front.sv */
module mf3_front import mf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  logic     acc,
  input  in_item_t item,
  output logic     push,
  output entry_t   push_entry,
  output logic     busy
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0]       eff_w;
  logic [ROW_BITS-1:0] eff_h;
  logic [CW-1:0]       in_column;
  logic [ROW_BITS:0]   in_row;
  logic [CW-1:0]       out_column;
  logic [ROW_BITS-1:0] out_row;

  // stage one: item registered with its read address, read data lands alongside
  logic                s1_valid;
  logic [CW-1:0]       s1_addr;
  pixel_t              s1_pix;
  logic                s1_produce;
  logic [WIN_SIZE-1:0] s1_mask;
  logic                s1_last;
  pixel_t              rd_prev;
  pixel_t              rd_older;

  // last line store write, for the read-after-write collision
  logic                lw_valid;
  logic [CW-1:0]       lw_addr;
  pixel_t              lw_pix;
  pixel_t              lw_prev;

  pixel_t              prev_mem  [MAX_WIDTH];
  pixel_t              older_mem [MAX_WIDTH];
  pixel_t [WIN_SIZE-1:0] win;
  pixel_t [WIN_SIZE-1:0] win_next;

  logic        ignore;
  logic        act;
  logic        produce;
  logic        last;
  logic        in_col_wrap;
  logic [2:0]  col_ok;
  logic [2:0]  row_ok;
  logic [WIN_SIZE-1:0] mask;
  pixel_t      pix;
  pixel_t      eff_prev;
  pixel_t      eff_older;
  logic [31:0] wv;

  assign wv     = 32'(cfg.data[10:0]);
  assign ignore = (32'(in_row) < 32'(eff_h)) && !item.pixel_valid;
  assign act    = acc && !ignore;
  assign produce = (32'(in_row) >= 32'd2) || (in_row == (ROW_BITS+1)'(1) && in_column != '0);
  assign last   = (32'(out_row) + 32'd1 >= 32'(eff_h)) &&
                  (32'(out_column) + 32'd1 >= 32'(eff_w));
  assign in_col_wrap = 32'(in_column) + 32'd1 >= 32'(eff_w);
  assign pix    = '{r: item.red_in, g: item.green_in, b: item.blue_in};

  assign col_ok = {32'(out_column) + 32'd1 < 32'(eff_w), 1'b1, out_column != '0};
  assign row_ok = {32'(out_row) + 32'd1 < 32'(eff_h), 1'b1, out_row != '0};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        mask[c*3+r] = col_ok[c] && row_ok[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w      <= WW'(MAX_WIDTH);
      eff_h      <= ROW_BITS'(1);
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      s1_valid   <= 1'b0;
      lw_valid   <= 1'b0;
    end else begin
      s1_valid <= act;
      lw_valid <= s1_valid;
      if (cfg.we) begin
        if (cfg.index == REG_IMAGE_WIDTH) begin
          eff_w <= (wv == 32'd0) ? WW'(1) :
                   (wv > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wv);
        end else if (cfg.index == REG_IMAGE_HEIGHT) begin
          eff_h <= (cfg.data == '0) ? ROW_BITS'(1) : cfg.data;
        end
        if (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end
      end else if (act) begin
        if (produce && last) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else begin
          if (produce) begin
            if (32'(out_column) + 32'd1 >= 32'(eff_w)) begin
              out_column <= '0;
              out_row    <= out_row + ROW_BITS'(1);
            end else begin
              out_column <= out_column + CW'(1);
            end
          end
          if (in_col_wrap) begin
            in_column <= '0;
            in_row    <= in_row + (ROW_BITS+1)'(1);
          end else begin
            in_column <= in_column + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_addr    <= in_column;
      s1_pix     <= pix;
      s1_produce <= produce;
      s1_mask    <= mask;
      s1_last    <= last;
      rd_prev    <= prev_mem[in_column];
      rd_older   <= older_mem[in_column];
    end
    if (s1_valid) begin
      prev_mem[s1_addr]  <= s1_pix;
      older_mem[s1_addr] <= eff_prev;
      lw_addr <= s1_addr;
      lw_pix  <= s1_pix;
      lw_prev <= eff_prev;
      win     <= win_next;
    end
  end

  always_comb begin
    if (lw_valid && lw_addr == s1_addr) begin
      eff_prev  = lw_pix;
      eff_older = lw_prev;
    end else begin
      eff_prev  = rd_prev;
      eff_older = rd_older;
    end
    win_next      = win;
    win_next[5:0] = win[8:3];
    win_next[6]   = eff_older;
    win_next[7]   = eff_prev;
    win_next[8]   = s1_pix;
  end

  assign push       = s1_valid && s1_produce;
  assign push_entry = '{win: win_next, mask: s1_mask, last: s1_last};
  assign busy       = s1_valid;

endmodule

/* rtl/mf3_queue.sv */
module mf3_queue import mf3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    AW'(wr_ptr - rd_ptr) == AW'(count))
    else $error("queue pointers disagree with count");

endmodule

/* rtl/mf3_back.sv */
module mf3_back import mf3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  function automatic logic [CHAN_BITS-1:0] median(
    input logic [WIN_SIZE-1:0][CHAN_BITS-1:0] v,
    input logic [WIN_SIZE-1:0] m
  );
    logic [3:0] cnt;
    logic [3:0] rank;
    logic [CHAN_BITS-1:0] res;
    cnt = '0;
    res = '0;
    for (int i = 0; i < WIN_SIZE; i++) cnt = cnt + 4'(m[i]);
    for (int i = 0; i < WIN_SIZE; i++) begin
      rank = '0;
      for (int j = 0; j < WIN_SIZE; j++) begin
        if (m[j] && ((v[j] < v[i]) || (v[j] == v[i] && j < i))) rank = rank + 4'd1;
      end
      if (m[i] && rank == (cnt >> 1)) res = v[i];
    end
    return res;
  endfunction

  logic [WIN_SIZE-1:0][CHAN_BITS-1:0] rv, gv, bv;

  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      rv[i] = head.win[i].r;
      gv[i] = head.win[i].g;
      bv[i] = head.win[i].b;
    end
  end

  assign pop = !empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= '{red_out:   median(rv, head.mask),
                    green_out: median(gv, head.mask),
                    blue_out:  median(bv, head.mask),
                    frame_end: head.last};
    end
  end

endmodule

/* rtl/median_filter_3x3_rgb_top.sv */
// 3x3 median filter on a raster rgb stream. one pixel transaction per clock;
// each result is the per-channel median of the border-clipped neighbourhood
// (9, 6, 4, 3, 2 or 1 pixels, upper median when even) of the pixel width+1
// transactions back, so width+1 flush transactions (pixel_valid low) after
// the last pixel drain the frame; frame_end marks the frame's last result.
// while the frame is still arriving, a transaction with pixel_valid low is
// dropped. writing image_width or image_height restarts the frame and must
// only be done by the user while idle; the block does not enforce it. the
// two line stores are single-write memories, the front holds them and the
// window, and a four-entry queue decouples it from the median and output
// register, so sustained rate is one transaction per cycle unless stalled
module median_filter_3x3_rgb_top import mf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cfg_wr_t        cfg;
  logic           push;
  entry_t         push_entry;
  logic           busy;
  logic           pop;
  entry_t         head;
  logic           empty;
  logic [QCW-1:0] count;

  // config always taken at once
  assign cfg_ready = 1'b1;
  assign cfg = '{we: cfg_valid, index: cfg_index, data: cfg_data};

  // credit check: queue entries plus the one transaction still in the front
  assign in_stall = (32'(count) + 32'(busy)) >= 32'(QUEUE_DEPTH);

  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .cfg,
    .acc(in_valid && !in_stall),
    .item(in_data),
    .push, .push_entry, .busy
  );

  mf3_queue u_queue (
    .clk, .rst, .push, .push_entry, .pop, .head, .empty, .count
  );

  mf3_back u_back (
    .clk, .rst, .head, .empty, .pop, .out_valid, .out_stall, .out_data
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mf3_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_ITEMS   = 400;
  localparam int MAX_W        = 1024;

  // pixel patterns for frame content
  localparam int PAT_RANDOM = 0;
  localparam int PAT_ZERO   = 1;
  localparam int PAT_FULL   = 2;
  localparam int PAT_RAMP   = 3;
  localparam int PAT_TIES   = 4;

  // register indexes past the list, must be ignored
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [11:0] cfg_data = '0;

  median_filter_3x3_rgb_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // median predictor: own copy of line stores, window and positions
  // ---------------------------------------------------------------
  logic [23:0] prev_line [MAX_W];
  logic [23:0] older_line [MAX_W];
  logic [23:0] nbhd [9];
  int          in_col, in_row, out_col, out_row;
  int          width_reg, height_reg;

  out_item_t   median_q [$];      // medians still to come out of the block
  int          fails = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          frames_done = 0;
  int          cycles = 0;

  bit          tx_fast = 1'b0;    // sender without gaps
  bit          rx_fast = 1'b0;    // receiver without stalls
  logic        hold_on = 1'b0;    // long receiver hold-off

  function automatic int eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  function automatic void clear_positions();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // median of one channel over the border-clipped window
  function automatic logic [7:0] chan_median(int shift, int w, int h);
    logic [7:0] vals [9];
    logic [7:0] v;
    int cnt, x, y, j;
    cnt = 0;
    for (int c = 0; c < 3; c++) begin
      x = out_col - 1 + c;
      if (x >= 0 && x < w) begin
        for (int r = 0; r < 3; r++) begin
          y = out_row - 1 + r;
          if (y >= 0 && y < h) begin
            vals[cnt] = 8'(nbhd[c*3+r] >> shift);
            cnt++;
          end
        end
      end
    end
    for (int i = 1; i < cnt; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[cnt/2];
  endfunction

  // advance the predictor by one accepted transaction
  function automatic bit predict_median(input in_item_t it, output out_item_t res);
    int w, h, pos, col;
    logic [23:0] pix;
    bit last, produced;
    w = eff_width();
    h = eff_height();
    pos = in_row * w + in_col;
    col = in_col % MAX_W;
    res = '0;
    produced = 1'b0;
    // pixel_valid low while the frame is still arriving is dropped
    if (pos < w * h && !it.pixel_valid) return 1'b0;
    pix = {it.red_in, it.green_in, it.blue_in};
    for (int i = 0; i < 6; i++) nbhd[i] = nbhd[i+3];
    nbhd[6] = older_line[col];
    nbhd[7] = prev_line[col];
    nbhd[8] = pix;
    older_line[col] = prev_line[col];
    prev_line[col] = pix;
    if (pos >= w + 1) begin
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red_out   = chan_median(16, w, h);
      res.green_out = chan_median(8, w, h);
      res.blue_out  = chan_median(0, w, h);
      res.frame_end = last;
      produced = 1'b1;
      if (last) begin
        clear_positions();
        return 1'b1;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    return produced;
  endfunction

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      prev_line[i] = '0;
      older_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    clear_positions();
    width_reg = 1024;
    height_reg = 1;
  end

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  // one pixel transaction, with a random gap before it
  task automatic send_item(input in_item_t it);
    int gap;
    out_item_t res;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (predict_median(it, res)) median_q.push_back(res);
  endtask

  function automatic logic [23:0] make_pixel(int pattern, int idx);
    logic [7:0] ties [4];
    ties = '{8'd0, 8'd1, 8'd254, 8'd255};
    case (pattern)
      PAT_ZERO: return 24'h000000;
      PAT_FULL: return 24'hffffff;
      PAT_RAMP: return {8'(idx * 37), 8'(idx * 91), 8'(255 - idx * 13)};
      PAT_TIES: return {ties[$urandom_range(0, 3)], ties[$urandom_range(0, 3)],
                        ties[$urandom_range(0, 3)]};
      default:  return 24'($urandom);
    endcase
  endfunction

  // whole frame at the current setting, then the drain transactions
  task automatic send_frame(int pattern, int noise_pct);
    int w, h;
    in_item_t it;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < w * h; i++) begin
      // dropped transactions in the middle of the frame
      if (i > 0 && $urandom_range(0, 99) < noise_pct) begin
        it = {1'b0, 24'($urandom)};
        send_item(it);
      end
      it = {1'b1, make_pixel(pattern, i)};
      send_item(it);
    end
    // drain: pixel_valid does not matter any more
    for (int i = 0; i <= w; i++) begin
      it = {1'($urandom_range(0, 1)), 24'($urandom)};
      send_item(it);
    end
    frames_done++;
  endtask

  // start of a frame only; the next register write restarts it
  task automatic send_partial(int pattern, int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = {1'b1, make_pixel(pattern, i)};
      send_item(it);
    end
  endtask

  // quiet the input, let the block go idle, then write one register
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    in_valid <= 1'b0;
    while (median_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = int'(data[10:0]);
        clear_positions();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = int'(data);
        clear_positions();
      end
      default: ;
    endcase
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_IMAGE_WIDTH, 12'(w));
    write_reg(REG_IMAGE_HEIGHT, 12'(h));
  endtask

  // ---------------------------------------------------------------
  // receiver side and result check
  // ---------------------------------------------------------------
  task automatic hold_receiver(int n);
    hold_on <= 1'b1;
    repeat (n) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  initial begin
    int stall_left;
    out_item_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (median_q.size() == 0) begin
          $error("result with no median waiting: %h", out_data);
          fails++;
        end else begin
          want = median_q.pop_front();
          if (out_data.red_out !== want.red_out) begin
            $error("red_out expected %0d got %0d", want.red_out, out_data.red_out);
            fails++;
          end
          if (out_data.green_out !== want.green_out) begin
            $error("green_out expected %0d got %0d", want.green_out, out_data.green_out);
            fails++;
          end
          if (out_data.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d got %0d", want.blue_out, out_data.blue_out);
            fails++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end expected %0d got %0d", want.frame_end, out_data.frame_end);
            fails++;
          end
        end
        stall_left = rx_fast ? 0 : $urandom_range(0, 17);
      end
      out_stall <= hold_on || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  // reset setting: start of one row of the widest frame, no result yet
  task automatic test_reset_setting();
    send_partial(PAT_RANDOM, 40);
  endtask

  // tiny frames: single pixel, 2x2 ramp, 3x3 with channel extremes
  task automatic test_small_frames();
    set_size(1, 1);
    send_frame(PAT_FULL, 0);
    set_size(2, 2);
    send_frame(PAT_RAMP, 0);
    set_size(3, 3);
    send_frame(PAT_TIES, 0);
  endtask

  // out-of-range register values and spare indexes
  task automatic test_register_clamps();
    set_size(0, 0);
    send_frame(PAT_ZERO, 0);
    write_reg(REG_SPARE_2, 12'hfff);
    write_reg(REG_SPARE_3, 12'h000);
    send_frame(PAT_RANDOM, 0);
    // all ones into width clamps to the widest row
    set_size(12'hfff, 2);
    send_partial(PAT_RANDOM, 40);
    // tallest frame, one column
    set_size(1, 4095);
    send_partial(PAT_RANDOM, 60);
    set_size(5, 1);
    send_frame(PAT_TIES, 20);
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    set_size(8, 6);
    tx_fast = 1'b1;
    fork
      hold_receiver(400);
    join_none
    send_frame(PAT_RANDOM, 0);
    tx_fast = 1'b0;
  endtask

  // random frame sizes and content, mostly small
  task automatic test_random_frames();
    int stop_at;
    stop_at = items_sent + RAND_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) set_size($urandom_range(1, 40), $urandom_range(1, 4));
      else set_size($urandom_range(1, 12), $urandom_range(1, 10));
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      send_frame(($urandom_range(0, 2) == 0) ? PAT_TIES : PAT_RANDOM,
                 $urandom_range(0, 15));
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_setting();
    test_small_frames();
    test_register_clamps();
    test_backpressure();
    test_random_frames();
    in_valid <= 1'b0;
    while (median_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d frames, %0d input transactions, %0d medians checked",
             frames_done, items_sent, results_seen);
    $display("full frames from 1x1 up, frame starts at 1024 wide and 4095 tall");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* median_filter_3x3_rgb_top.f */
rtl/mf3_pkg.sv
rtl/mf3_front.sv
rtl/mf3_queue.sv
rtl/mf3_back.sv
rtl/median_filter_3x3_rgb_top.sv
sim/tb_top.sv
